// ===== rtl/ppid_pkg.sv =====
// Shared types and constants for the positional PID controller.
package ppid_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 23;

  typedef enum logic [CfgIdxW-1:0] {
    RegGainP      = 3'd0,
    RegGainI      = 3'd1,
    RegGainD      = 3'd2,
    RegOutUpper   = 3'd3,
    RegOutLower   = 3'd4,
    RegIntegLimit = 3'd5
  } reg_idx_e;

  typedef enum logic {
    CmdCompute = 1'b0,
    CmdClear   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [15:0] out_upper;
    logic signed [15:0] out_lower;
    logic [22:0]        integ_limit;
  } cfg_t;

  typedef struct packed {
    logic               clr;
    logic signed [16:0] err;
    logic signed [24:0] integ;
    logic signed [17:0] deriv;
  } op_t;

endpackage

// ===== rtl/positional_pid_controller_unit.sv =====
// Top level of the positional PID controller: registers, front end, queue, back end.
// Throughput is one item per clock cycle while the output is not stalled. An
// accepted item updates the integral and previous error in the front end in the
// cycle it is taken, then enters a small queue (QueueDepth entries); the back end
// forms the three gain products, their sum, and the shifted and saturated drive
// over three registered steps before a result item is offered. The input stalls
// only when the queue is full, so a stalled output backs up into the queue before
// the input sees it. A clear item gives drive 0. The configuration port is always
// ready; write it only while the block is idle.
module positional_pid_controller_unit #(
  parameter int unsigned QueueDepth = ppid_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppid_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic signed [15:0]            setpoint_i,
  input  logic signed [15:0]            measured_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            drive_o
);
  import ppid_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push;
  op_t  push_op;
  logic q_full;
  logic pop;
  logic q_valid;
  op_t  q_op;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegGainP:      cfg_d.gain_p      = cfg_data_i[15:0];
        RegGainI:      cfg_d.gain_i      = cfg_data_i[15:0];
        RegGainD:      cfg_d.gain_d      = cfg_data_i[15:0];
        RegOutUpper:   cfg_d.out_upper   = cfg_data_i[15:0];
        RegOutLower:   cfg_d.out_lower   = cfg_data_i[15:0];
        RegIntegLimit: cfg_d.integ_limit = cfg_data_i;
        default:       cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= 16'sd256;
      cfg_q.gain_i      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.out_upper   <= 16'sh7FFF;
      cfg_q.out_lower   <= 16'sh8000;
      cfg_q.integ_limit <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .setpoint_i (setpoint_i),
    .measured_i (measured_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  ppid_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  ppid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o)
  );

endmodule

// ===== rtl/ppid_front.sv =====
// Front end: accept items, update integral and previous error, emit operand sets.
module ppid_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppid_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] measured_i,
  input  logic               q_full_i,
  output logic               push_o,
  output ppid_pkg::op_t      op_o
);
  import ppid_pkg::*;

  logic signed [24:0] integ_q, integ_d;
  logic signed [16:0] prev_q, prev_d;
  logic signed [16:0] err;
  logic signed [24:0] integ_sum;
  logic signed [24:0] lim_pos;
  logic signed [24:0] lim_neg;
  logic signed [24:0] integ_clamped;
  logic               is_clear;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign is_clear   = (cmd_e'(cmd_i) == CmdClear);

  assign err       = 17'(setpoint_i) - 17'(measured_i);
  assign integ_sum = integ_q + 25'(err);
  assign lim_pos   = signed'({2'b00, cfg_i.integ_limit});
  assign lim_neg   = -lim_pos;

  always_comb begin
    priority if (integ_sum > lim_pos) begin
      integ_clamped = lim_pos;
    end else if (integ_sum < lim_neg) begin
      integ_clamped = lim_neg;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  always_comb begin
    integ_d = integ_q;
    prev_d  = prev_q;
    if (push_o) begin
      if (is_clear) begin
        integ_d = '0;
        prev_d  = '0;
      end else begin
        integ_d = integ_clamped;
        prev_d  = err;
      end
    end
  end

  assign op_o.clr   = is_clear;
  assign op_o.err   = err;
  assign op_o.integ = integ_clamped;
  assign op_o.deriv = 18'(err) - 18'(prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
    end
  end

endmodule

// ===== rtl/ppid_queue.sv =====
// Short first-word-fall-through queue between front and back end.
module ppid_queue #(
  parameter int unsigned Depth = ppid_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppid_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ppid_pkg::op_t op_o
);
  import ppid_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/ppid_back.sv =====
// Back end: multiply, sum, shift, saturate and hold the result item.
module ppid_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppid_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  ppid_pkg::op_t      q_op_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_o
);
  import ppid_pkg::*;

  logic               s1_valid_q;
  logic               s1_clr_q;
  logic signed [32:0] prod_p_q;
  logic signed [40:0] prod_i_q;
  logic signed [33:0] prod_d_q;
  logic               s2_valid_q;
  logic               s2_clr_q;
  logic signed [41:0] sum_q, sum_d;
  logic               out_valid_q;
  logic signed [15:0] drive_q, drive_d;
  logic signed [33:0] shifted;
  logic               out_adv, s2_adv, s1_adv;

  assign out_adv = !out_valid_q || !out_stall_i;
  assign s2_adv  = !s2_valid_q || out_adv;
  assign s1_adv  = !s1_valid_q || s2_adv;
  assign pop_o   = q_valid_i && s1_adv;

  assign sum_d   = 42'(prod_p_q) + 42'(prod_i_q) + 42'(prod_d_q);
  assign shifted = sum_q[41:8];

  always_comb begin
    priority if (s2_clr_q) begin
      drive_d = '0;
    end else if (shifted > 34'(cfg_i.out_upper)) begin
      drive_d = cfg_i.out_upper;
    end else if (shifted < 34'(cfg_i.out_lower)) begin
      drive_d = cfg_i.out_lower;
    end else begin
      drive_d = shifted[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_clr_q <= q_op_i.clr;
      prod_p_q <= 33'(cfg_i.gain_p) * 33'(q_op_i.err);
      prod_i_q <= 41'(cfg_i.gain_i) * 41'(q_op_i.integ);
      prod_d_q <= 34'(cfg_i.gain_d) * 34'(q_op_i.deriv);
    end
    if (s1_valid_q && s2_adv) begin
      s2_clr_q <= s1_clr_q;
      sum_q    <= sum_d;
    end
    if (s2_valid_q && out_adv) begin
      drive_q <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule
